// File: src/assert_macros.svh
// Assertion macros for the circle collision step block.
// Clocked on aclk, disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define VCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define VCC_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define VCC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: src/vcc_pkg.sv
// Shared types, constants and helpers for the circle collision step block.
// No dependencies; imported by the controller, datapath and top level.
package vcc_pkg;

    localparam int MAX_PARTICLES = 64;
    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_Y = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING = 8'd3;

    localparam logic signed [20:0] ACCEL_X_RST = 21'sd0;
    localparam logic signed [20:0] ACCEL_Y_RST = -21'sd3495;
    localparam logic [27:0]        RADIUS_RST  = 28'd3221225;
    localparam logic [15:0]        DAMPING_RST = 16'd49152;

    localparam logic ACT_ADD = 1'b0;

    localparam logic signed [33:0] Q_ONE = 34'sd268435456;
    localparam logic [59:0]        SQRT_BIT0 = 60'd1 << 58;
    localparam logic [5:0]         DIV_STEPS = 6'd32;

    typedef enum logic [4:0] {
        S_IDLE, S_R2, S_R2S, S_V_RD, S_V_CALC, S_WX_MUL, S_WX_FIX, S_WY_MUL,
        S_WY_FIX, S_V_WR, S_I_RD, S_I_LD, S_J_RD, S_J_CHK, S_SQX, S_SQY, S_D2,
        S_D2CHK, S_SQRT, S_OV, S_MULX, S_MULY, S_DIVINIT, S_DIV, S_UPD,
        S_J_NEXT, S_I_WR, S_O_RD, S_O_SEND
    } state_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_ADD, OP_RD, OP_R2, OP_R2S, OP_VCALC, OP_WMULX, OP_WFIXX,
        OP_WMULY, OP_WFIXY, OP_VWR, OP_ILD, OP_JCHK, OP_SQX, OP_SQY, OP_D2,
        OP_D2CHK, OP_SQSTEP, OP_OV, OP_MULX, OP_MULY, OP_DIVINIT, OP_DIVSTEP,
        OP_UPD, OP_IWR
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [IDX_W-1:0] addr;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic sq_done;
        logic div_done;
    } stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// File: src/vcc_ctrl.sv
// Sequencer for the circle collision step block: add, integrate, wall, pair, report.
// Depends on vcc_pkg; drives vcc_dp through cmd_t and reads stat_t back.
module vcc_ctrl import vcc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             s_action,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic             m_tlast,
    output logic [IDX_W-1:0] out_idx,
    input  stat_t            stat,
    output cmd_t             cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IDX_W-1:0] last_idx;
    logic             full;

    assign last_idx = IDX_W'(cnt_reg - CNT_W'(1));
    assign full     = (cnt_reg == CNT_W'(MAX_PARTICLES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_action == ACT_ADD) begin
                        if (!full) begin
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end else if (cnt_reg != '0) begin
                        state_next = S_R2;
                    end
                end
            end
            S_R2:     state_next = S_R2S;
            S_R2S: begin
                k_next     = '0;
                state_next = S_V_RD;
            end
            S_V_RD:   state_next = S_V_CALC;
            S_V_CALC: state_next = S_WX_MUL;
            S_WX_MUL: state_next = S_WX_FIX;
            S_WX_FIX: state_next = S_WY_MUL;
            S_WY_MUL: state_next = S_WY_FIX;
            S_WY_FIX: state_next = S_V_WR;
            S_V_WR: begin
                if (k_reg == last_idx) begin
                    i_next     = '0;
                    state_next = S_I_RD;
                end else begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = S_V_RD;
                end
            end
            S_I_RD:   state_next = S_I_LD;
            S_I_LD: begin
                j_next     = '0;
                state_next = S_J_RD;
            end
            S_J_RD:   state_next = S_J_CHK;
            S_J_CHK:  state_next = (stat.skip || j_reg == i_reg) ? S_J_NEXT : S_SQX;
            S_SQX:    state_next = S_SQY;
            S_SQY:    state_next = S_D2;
            S_D2:     state_next = S_D2CHK;
            S_D2CHK:  state_next = stat.skip ? S_J_NEXT : S_SQRT;
            S_SQRT: begin
                if (stat.sq_done) begin
                    state_next = S_OV;
                end
            end
            S_OV:      state_next = stat.skip ? S_J_NEXT : S_MULX;
            S_MULX:    state_next = S_MULY;
            S_MULY:    state_next = S_DIVINIT;
            S_DIVINIT: state_next = S_DIV;
            S_DIV: begin
                if (stat.div_done) begin
                    state_next = S_UPD;
                end
            end
            S_UPD:    state_next = S_J_NEXT;
            S_J_NEXT: begin
                if (j_reg == last_idx) begin
                    state_next = S_I_WR;
                end else begin
                    j_next     = j_reg + IDX_W'(1);
                    state_next = S_J_RD;
                end
            end
            S_I_WR: begin
                if (i_reg == last_idx) begin
                    k_next     = '0;
                    state_next = S_O_RD;
                end else begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_I_RD;
                end
            end
            S_O_RD:   state_next = S_O_SEND;
            S_O_SEND: begin
                if (m_tready) begin
                    if (k_reg == last_idx) begin
                        state_next = S_IDLE;
                    end else begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = S_O_RD;
                    end
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == S_IDLE);
        m_tvalid = (state_reg == S_O_SEND);
        m_tlast  = (k_reg == last_idx);
        out_idx  = k_reg;
        cmd.op   = OP_NOP;
        cmd.addr = k_reg;
        case (state_reg)
            S_IDLE: begin
                cmd.addr = cnt_reg[IDX_W-1:0];
                if (s_tvalid && s_action == ACT_ADD && !full) begin
                    cmd.op = OP_ADD;
                end
            end
            S_R2:      cmd.op = OP_R2;
            S_R2S:     cmd.op = OP_R2S;
            S_V_RD:    cmd.op = OP_RD;
            S_V_CALC:  cmd.op = OP_VCALC;
            S_WX_MUL:  cmd.op = OP_WMULX;
            S_WX_FIX:  cmd.op = OP_WFIXX;
            S_WY_MUL:  cmd.op = OP_WMULY;
            S_WY_FIX:  cmd.op = OP_WFIXY;
            S_V_WR:    cmd.op = OP_VWR;
            S_I_RD: begin
                cmd.op   = OP_RD;
                cmd.addr = i_reg;
            end
            S_I_LD: begin
                cmd.op   = OP_ILD;
                cmd.addr = i_reg;
            end
            S_J_RD: begin
                cmd.op   = OP_RD;
                cmd.addr = j_reg;
            end
            S_J_CHK: begin
                cmd.op   = OP_JCHK;
                cmd.addr = j_reg;
            end
            S_SQX:     cmd.op = OP_SQX;
            S_SQY:     cmd.op = OP_SQY;
            S_D2:      cmd.op = OP_D2;
            S_D2CHK:   cmd.op = OP_D2CHK;
            S_SQRT:    cmd.op = stat.sq_done ? OP_NOP : OP_SQSTEP;
            S_OV:      cmd.op = OP_OV;
            S_MULX:    cmd.op = OP_MULX;
            S_MULY:    cmd.op = OP_MULY;
            S_DIVINIT: cmd.op = OP_DIVINIT;
            S_DIV:     cmd.op = stat.div_done ? OP_NOP : OP_DIVSTEP;
            S_UPD: begin
                cmd.op   = OP_UPD;
                cmd.addr = j_reg;
            end
            S_I_WR: begin
                cmd.op   = OP_IWR;
                cmd.addr = i_reg;
            end
            S_O_RD:    cmd.op = OP_RD;
            S_O_SEND:  cmd.op = OP_RD;
            default:   cmd.op = OP_NOP;
        endcase
    end

endmodule

// File: src/vcc_dp.sv
// Datapath: circle stores, shared multiplier, square root and twin dividers.
// Depends on vcc_pkg; steered by cmd_t from vcc_ctrl, reports stat_t.
module vcc_dp import vcc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] in_px,
    input  logic signed [31:0] in_py,
    input  cmd_t               cmd,
    output stat_t              stat,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y
);

    logic [63:0] pos_mem  [MAX_PARTICLES];
    logic [63:0] prev_mem [MAX_PARTICLES];
    logic [63:0] pos_rd_reg, prev_rd_reg;
    logic        pos_we, prev_we;
    logic [63:0] pos_wdata, prev_wdata;

    logic signed [20:0] accel_x_reg, accel_y_reg;
    logic [27:0]        radius_reg;
    logic [15:0]        damp_reg;

    logic signed [63:0] mul_reg, mul_next;
    logic [55:0]        r2_reg, r2_next;
    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic signed [31:0] qx_reg, qx_next, qy_reg, qy_next;
    logic               whit_reg, whit_next;
    logic signed [33:0] wall_reg, wall_next;
    logic signed [31:0] xi_reg, xi_next, yi_reg, yi_next;
    logic signed [31:0] xj_reg, xj_next, yj_reg, yj_next;
    logic signed [29:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [59:0]        d2_reg, d2_next;
    logic [59:0]        sq_v_reg, sq_v_next, sq_r_reg, sq_r_next, sq_bit_reg, sq_bit_next;
    logic signed [30:0] ov_reg, ov_next;
    logic signed [63:0] numx_reg, numx_next;
    logic [30:0]        remx_reg, remx_next, remy_reg, remy_next;
    logic [31:0]        dqx_reg, dqx_next, dqy_reg, dqy_next;
    logic               negx_reg, negx_next, negy_reg, negy_next;
    logic [5:0]         div_cnt_reg, div_cnt_next;

    logic signed [33:0] mul_a;
    logic signed [30:0] mul_b;
    logic signed [64:0] prod;
    logic signed [31:0] rd_x, rd_y, rd_qx, rd_qy;
    logic signed [33:0] lo, hi;
    logic [28:0]        rs;
    logic [57:0]        rs2;
    logic [29:0]        sep;
    logic [30:0]        den;
    logic signed [32:0] ddx, ddy;
    logic [32:0]        adx, ady;
    logic [63:0]        d10;
    logic [59:0]        sq_t;
    logic [63:0]        magx, magy, ax, ay;
    logic [62:0]        stx, sty;
    logic signed [63:0] sx, sy, rnd;
    logic               pair_skip;

    function automatic logic [62:0] div_step(input logic [30:0] rem, input logic [31:0] dq,
                                             input logic [30:0] dv);
        logic [31:0] t;
        logic        q;
        t = {rem, dq[31]};
        q = (t >= {1'b0, dv});
        if (q) begin
            t = t - {1'b0, dv};
        end
        return {t[30:0], dq[30:0], q};
    endfunction

    assign prod  = mul_a * mul_b;
    assign rd_x  = pos_rd_reg[31:0];
    assign rd_y  = pos_rd_reg[63:32];
    assign rd_qx = prev_rd_reg[31:0];
    assign rd_qy = prev_rd_reg[63:32];
    assign lo    = $signed({6'd0, radius_reg}) - Q_ONE;
    assign hi    = Q_ONE - $signed({6'd0, radius_reg});
    assign rs    = {radius_reg, 1'b0};
    assign rs2   = {r2_reg, 2'b00};
    assign sep   = sq_r_reg[29:0];
    assign den   = {sep, 1'b0};
    assign ddx   = 33'(xi_reg) - 33'(rd_x);
    assign ddy   = 33'(yi_reg) - 33'(rd_y);
    assign adx   = ddx[32] ? 33'(-ddx) : 33'(ddx);
    assign ady   = ddy[32] ? 33'(-ddy) : 33'(ddy);
    assign d10   = {1'b0, d2_reg, 3'b000} + {3'b000, d2_reg, 1'b0};
    assign sq_t  = sq_r_reg + sq_bit_reg;
    assign magx  = numx_reg[63] ? 64'(-numx_reg) : 64'(numx_reg);
    assign magy  = mul_reg[63] ? 64'(-mul_reg) : 64'(mul_reg);
    assign ax    = magx + {34'd0, sep};
    assign ay    = magy + {34'd0, sep};
    assign stx   = div_step(remx_reg, dqx_reg, den);
    assign sty   = div_step(remy_reg, dqy_reg, den);
    assign sx    = negx_reg ? -$signed({32'd0, dqx_reg}) : $signed({32'd0, dqx_reg});
    assign sy    = negy_reg ? -$signed({32'd0, dqy_reg}) : $signed({32'd0, dqy_reg});
    assign rnd   = (mul_reg + 64'sd32768) >>> 16;

    assign stat.skip     = pair_skip;
    assign stat.sq_done  = (sq_bit_reg == '0);
    assign stat.div_done = (div_cnt_reg == DIV_STEPS);
    assign out_x = rd_x;
    assign out_y = rd_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_x_reg <= ACCEL_X_RST;
            accel_y_reg <= ACCEL_Y_RST;
            radius_reg  <= RADIUS_RST;
            damp_reg    <= DAMPING_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ACCEL_X: accel_x_reg <= cfg_data[20:0];
                CFG_ACCEL_Y: accel_y_reg <= cfg_data[20:0];
                CFG_RADIUS:  radius_reg  <= cfg_data[27:0];
                CFG_DAMPING: damp_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[cmd.addr] <= pos_wdata;
        end
        if (prev_we) begin
            prev_mem[cmd.addr] <= prev_wdata;
        end
        pos_rd_reg  <= pos_mem[cmd.addr];
        prev_rd_reg <= prev_mem[cmd.addr];
    end

    always_ff @(posedge aclk) begin
        mul_reg     <= mul_next;
        r2_reg      <= r2_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        qx_reg      <= qx_next;
        qy_reg      <= qy_next;
        whit_reg    <= whit_next;
        wall_reg    <= wall_next;
        xi_reg      <= xi_next;
        yi_reg      <= yi_next;
        xj_reg      <= xj_next;
        yj_reg      <= yj_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        d2_reg      <= d2_next;
        sq_v_reg    <= sq_v_next;
        sq_r_reg    <= sq_r_next;
        sq_bit_reg  <= sq_bit_next;
        ov_reg      <= ov_next;
        numx_reg    <= numx_next;
        remx_reg    <= remx_next;
        remy_reg    <= remy_next;
        dqx_reg     <= dqx_next;
        dqy_reg     <= dqy_next;
        negx_reg    <= negx_next;
        negy_reg    <= negy_next;
        div_cnt_reg <= div_cnt_next;
    end

    always_comb begin
        mul_next     = mul_reg;
        r2_next      = r2_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        qx_next      = qx_reg;
        qy_next      = qy_reg;
        whit_next    = whit_reg;
        wall_next    = wall_reg;
        xi_next      = xi_reg;
        yi_next      = yi_reg;
        xj_next      = xj_reg;
        yj_next      = yj_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        d2_next      = d2_reg;
        sq_v_next    = sq_v_reg;
        sq_r_next    = sq_r_reg;
        sq_bit_next  = sq_bit_reg;
        ov_next      = ov_reg;
        numx_next    = numx_reg;
        remx_next    = remx_reg;
        remy_next    = remy_reg;
        dqx_next     = dqx_reg;
        dqy_next     = dqy_reg;
        negx_next    = negx_reg;
        negy_next    = negy_reg;
        div_cnt_next = div_cnt_reg;
        mul_a        = '0;
        mul_b        = '0;
        pair_skip    = 1'b0;
        pos_we       = 1'b0;
        prev_we      = 1'b0;
        pos_wdata    = {yi_reg, xi_reg};
        prev_wdata   = {qy_reg, qx_reg};
        case (cmd.op)
            OP_ADD: begin
                pos_we     = 1'b1;
                prev_we    = 1'b1;
                pos_wdata  = {in_y, in_x};
                prev_wdata = {in_py, in_px};
            end
            OP_R2: begin
                mul_a    = $signed({6'd0, radius_reg});
                mul_b    = $signed({3'd0, radius_reg});
                mul_next = prod[63:0];
            end
            OP_R2S: r2_next = mul_reg[55:0];
            OP_VCALC: begin
                px_next = sat32((64'(rd_x) <<< 1) - 64'(rd_qx) + 64'(accel_x_reg));
                py_next = sat32((64'(rd_y) <<< 1) - 64'(rd_qy) + 64'(accel_y_reg));
                qx_next = rd_x;
                qy_next = rd_y;
            end
            OP_WMULX, OP_WMULY: begin
                if (cmd.op == OP_WMULX) begin
                    mul_a = 34'(px_reg) - 34'(qx_reg);
                    whit_next = (34'(px_reg) <= lo) || (34'(px_reg) >= hi);
                    wall_next = (34'(px_reg) <= lo) ? lo : hi;
                end else begin
                    mul_a = 34'(py_reg) - 34'(qy_reg);
                    whit_next = (34'(py_reg) <= lo) || (34'(py_reg) >= hi);
                    wall_next = (34'(py_reg) <= lo) ? lo : hi;
                end
                mul_b    = $signed({15'd0, damp_reg});
                mul_next = prod[63:0];
            end
            OP_WFIXX: begin
                if (whit_reg) begin
                    qx_next = sat32(64'(wall_reg) + rnd);
                    px_next = sat32(64'(wall_reg));
                end
            end
            OP_WFIXY: begin
                if (whit_reg) begin
                    qy_next = sat32(64'(wall_reg) + rnd);
                    py_next = sat32(64'(wall_reg));
                end
            end
            OP_VWR: begin
                pos_we     = 1'b1;
                prev_we    = 1'b1;
                pos_wdata  = {py_reg, px_reg};
                prev_wdata = {qy_reg, qx_reg};
            end
            OP_ILD: begin
                xi_next = rd_x;
                yi_next = rd_y;
            end
            OP_JCHK: begin
                xj_next   = rd_x;
                yj_next   = rd_y;
                dx_next   = ddx[29:0];
                dy_next   = ddy[29:0];
                pair_skip = (adx >= {4'd0, rs}) || (ady >= {4'd0, rs});
            end
            OP_SQX: begin
                mul_a    = 34'(dx_reg);
                mul_b    = 31'(dx_reg);
                mul_next = prod[63:0];
            end
            OP_SQY: begin
                mul_a    = 34'(dy_reg);
                mul_b    = 31'(dy_reg);
                mul_next = prod[63:0];
                d2_next  = mul_reg[59:0];
            end
            OP_D2: d2_next = d2_reg + mul_reg[59:0];
            OP_D2CHK: begin
                pair_skip   = !((d2_reg < {2'b00, rs2}) && (d10 > {8'd0, r2_reg}));
                sq_v_next   = d2_reg;
                sq_r_next   = '0;
                sq_bit_next = SQRT_BIT0;
            end
            OP_SQSTEP: begin
                if (sq_v_reg >= sq_t) begin
                    sq_v_next = sq_v_reg - sq_t;
                    sq_r_next = (sq_r_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_r_next = sq_r_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
            end
            OP_OV: begin
                pair_skip = (sep == '0);
                ov_next   = $signed({2'b00, rs}) - $signed({1'b0, sep});
            end
            OP_MULX: begin
                mul_a    = 34'(dx_reg);
                mul_b    = ov_reg;
                mul_next = prod[63:0];
            end
            OP_MULY: begin
                mul_a     = 34'(dy_reg);
                mul_b     = ov_reg;
                mul_next  = prod[63:0];
                numx_next = mul_reg;
            end
            OP_DIVINIT: begin
                remx_next    = ax[62:32];
                dqx_next     = ax[31:0];
                negx_next    = numx_reg[63];
                remy_next    = ay[62:32];
                dqy_next     = ay[31:0];
                negy_next    = mul_reg[63];
                div_cnt_next = '0;
            end
            OP_DIVSTEP: begin
                remx_next    = stx[62:32];
                dqx_next     = stx[31:0];
                remy_next    = sty[62:32];
                dqy_next     = sty[31:0];
                div_cnt_next = div_cnt_reg + 6'd1;
            end
            OP_UPD: begin
                xi_next   = sat32(64'(xi_reg) + sx);
                yi_next   = sat32(64'(yi_reg) + sy);
                pos_we    = 1'b1;
                pos_wdata = {sat32(64'(yj_reg) - sy), sat32(64'(xj_reg) - sx)};
            end
            OP_IWR: begin
                pos_we    = 1'b1;
                pos_wdata = {yi_reg, xi_reg};
            end
            default: ;
        endcase
    end

endmodule

// File: src/verlet_circle_collision_step.sv
// Top level of the circle collision step block: stream ports, config port, checks.
// Depends on vcc_pkg, vcc_ctrl, vcc_dp and assert_macros.svh.
//
//  channel | direction | beat carries
//  s_      | in        | tuser: action; tdata: new_x, new_y, new_prev_x, new_prev_y
//  m_      | out       | tdata: circle_index, out_x, out_y; tlast: last_circle
//  cfg_    | in        | cfg_index, cfg_data (one register per beat)
//
// An add beat is written to the stores when taken. A step integrates each circle and
// applies the walls, then checks each ordered pair (a miss ends at the box, distance or
// zero-root test; a hit runs a 30-step square root and a 32-step divide), writes back
// each outer row, then sends one result per circle.
// Reset is synchronous, active low; the stores are not cleared.
// A stalled result holds the block; no input beat is taken during a step.
`include "assert_macros.svh"
module verlet_circle_collision_step import vcc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [127:0]         s_tdata,   // new_x, new_y, new_prev_x, new_prev_y
    input  logic                 s_tuser,   // action
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,   // circle_index, out_x, out_y, zero pad
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    cmd_t               cmd;
    stat_t              stat;
    logic [IDX_W-1:0]   out_idx;
    logic signed [31:0] out_x, out_y;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {2'b00, out_y, out_x, 6'(out_idx)};

    vcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_action (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .out_idx  (out_idx),
        .stat     (stat),
        .cmd      (cmd)
    );

    vcc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_x      (s_tdata[31:0]),
        .in_y      (s_tdata[63:32]),
        .in_px     (s_tdata[95:64]),
        .in_py     (s_tdata[127:96]),
        .cmd       (cmd),
        .stat      (stat),
        .out_x     (out_x),
        .out_y     (out_y)
    );

    `VCC_ASSERT(a_no_overlap, !(s_tready && m_tvalid), "input and output open together")
    `VCC_ASSERT_IMPL(a_add_on_beat, cmd.op == OP_ADD, s_tvalid && s_tready,
        "store written without an input beat")
    `VCC_ASSERT_NEXT(a_busy_mid_report, m_tvalid && m_tready && !m_tlast, !s_tready,
        "input reopened before the report ended")

endmodule

// File: dv/verlet_circle_collision_step_test.sv
// Self-checking bench for verlet_circle_collision_step: directed and random add/step beats,
// config phases, random idling and a long result hold-off, checked by a scoreboard.
// Depends on vcc_pkg and the block's RTL only.
`timescale 1ns / 1ps
module verlet_circle_collision_step_test;
    import vcc_pkg::*;

    localparam int HANG_LIMIT = 2000000;
    localparam int Q1 = 268435456;

    typedef struct {
        logic [5:0] idx;
        int         x;
        int         y;
        logic       last;
    } circle_pos_t;

    class circle_scoreboard;
        int px[64], py[64], qx[64], qy[64];
        int count;
        longint ax, ay, rad, damp;
        circle_pos_t pos_q[$];
        int errors;

        function new();
            count = 0;
            ax = ACCEL_X_RST;
            ay = ACCEL_Y_RST;
            rad = RADIUS_RST;
            damp = DAMPING_RST;
            errors = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint round_div(longint num, longint den);
            longint unsigned a, q;
            a = (num < 0) ? -num : num;
            q = (a + den / 2) / den;
            return (num < 0) ? -longint'(q) : longint'(q);
        endfunction

        function void bounce(inout int p, inout int q, input longint lo, input longint hi);
            longint w, d;
            if (p <= lo) w = lo;
            else if (p >= hi) w = hi;
            else return;
            d = (longint'(p) - q) * damp + 32768;
            q = int'(clamp32(w + (d >>> 16)));
            p = int'(clamp32(w));
        endfunction

        function void write_reg(logic [7:0] idx, logic [31:0] d);
            case (idx)
                CFG_ACCEL_X: ax = longint'($signed(d[20:0]));
                CFG_ACCEL_Y: ay = longint'($signed(d[20:0]));
                CFG_RADIUS:  rad = longint'(d[27:0]);
                CFG_DAMPING: damp = longint'(d[15:0]);
                default: ;
            endcase
        endfunction

        function void advance();
            longint rs, rs2, r2, lo, hi, x, y, dx, dy, d2, sep, ov, sx, sy;
            circle_pos_t e;
            rs = 2 * rad;
            rs2 = rs * rs;
            r2 = rad * rad;
            lo = -Q1 + rad;
            hi = Q1 - rad;
            for (int i = 0; i < count; i++) begin
                x = px[i];
                y = py[i];
                px[i] = int'(clamp32(2 * x - qx[i] + ax));
                py[i] = int'(clamp32(2 * y - qy[i] + ay));
                qx[i] = int'(x);
                qy[i] = int'(y);
            end
            for (int i = 0; i < count; i++) begin
                bounce(px[i], qx[i], lo, hi);
                bounce(py[i], qy[i], lo, hi);
            end
            for (int i = 0; i < count; i++) begin
                for (int j = 0; j < count; j++) begin
                    dx = longint'(px[i]) - px[j];
                    dy = longint'(py[i]) - py[j];
                    if (dx >= rs || -dx >= rs || dy >= rs || -dy >= rs) continue;
                    d2 = dx * dx + dy * dy;
                    if (!(d2 < rs2 && 10 * d2 > r2)) continue;
                    sep = longint'(root(d2));
                    if (sep < 1) continue;
                    ov = rs - sep;
                    sx = round_div(dx * ov, 2 * sep);
                    sy = round_div(dy * ov, 2 * sep);
                    px[i] = int'(clamp32(longint'(px[i]) + sx));
                    py[i] = int'(clamp32(longint'(py[i]) + sy));
                    px[j] = int'(clamp32(longint'(px[j]) - sx));
                    py[j] = int'(clamp32(longint'(py[j]) - sy));
                end
            end
            for (int k = 0; k < count; k++) begin
                e.idx = k[5:0];
                e.x = px[k];
                e.y = py[k];
                e.last = (k + 1 == count);
                pos_q = {pos_q, e};
            end
        endfunction

        function void note_input(logic act, logic [127:0] d);
            if (act == ACT_ADD) begin
                if (count < MAX_PARTICLES) begin
                    px[count] = d[31:0];
                    py[count] = d[63:32];
                    qx[count] = d[95:64];
                    qy[count] = d[127:96];
                    count++;
                end
            end else begin
                advance();
            end
        endfunction

        function void check_result(logic [5:0] idx, logic [31:0] x, logic [31:0] y,
                                   logic last);
            circle_pos_t e;
            if (pos_q.size() == 0) begin
                if (errors < 10) $display("unexpected beat: idx %0d x %h y %h", idx, x, y);
                errors++;
                return;
            end
            e = pos_q.pop_front();
            if (idx !== e.idx || x !== e.x || y !== e.y || last !== e.last) begin
                if (errors < 10)
                    $display("mismatch: exp idx %0d x %h y %h last %0d, got idx %0d x %h y %h last %0d",
                             e.idx, e.x, e.y, e.last, idx, x, y, last);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [127:0]         s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [71:0]          m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    circle_scoreboard sb = new();
    bit   idle_en;
    bit   hold_req;
    int   stall_left;
    int   quiet_cycles;

    verlet_circle_collision_step uut (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[5:0], m_tdata[37:6], m_tdata[69:38], m_tlast);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = 1500;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("verlet_circle_collision_step regression: fail");
            $finish;
        end
    end

    task automatic send_item(logic act, int x, int y, int px_, int py_);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {py_, px_, y, x};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(act, {py_, px_, y, x});
    endtask

    task automatic run_step();
        send_item(~ACT_ADD, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic rand_add();
        int x, y, k, rr;
        if ($urandom_range(0, 9) == 0) begin
            send_item(ACT_ADD, $urandom, $urandom, $urandom, $urandom);
            return;
        end
        rr = int'(sb.rad);
        if (sb.count > 0 && $urandom_range(0, 2) == 0) begin
            k = $urandom_range(0, sb.count - 1);
            x = sb.px[k] + int'($urandom_range(0, 4 * rr)) - 2 * rr;
            y = sb.py[k] + int'($urandom_range(0, 4 * rr)) - 2 * rr;
        end else begin
            x = int'($urandom_range(0, 2 * Q1)) - Q1;
            y = int'($urandom_range(0, 2 * Q1)) - Q1;
        end
        send_item(ACT_ADD, x, y, x + int'($urandom_range(0, 131072)) - 65536,
                  y + int'($urandom_range(0, 131072)) - 65536);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pos_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [7:0] idx, logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, d);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_all(logic [31:0] ax, logic [31:0] ay, logic [31:0] r, logic [31:0] dm);
        settle();
        cfg_write(CFG_ACCEL_X, ax);
        cfg_write(CFG_ACCEL_Y, ay);
        cfg_write(CFG_RADIUS, r);
        cfg_write(CFG_DAMPING, dm);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_req = 1'b0;
        idle_en = 1'b1;
        quiet_cycles = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty step, saturation, overlapping and coincident circles, walls
        run_step();
        send_item(ACT_ADD, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
        send_item(ACT_ADD, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        send_item(ACT_ADD, 0, 0, 0, 0);
        send_item(ACT_ADD, 3221225, 0, 3221225, 0);
        send_item(ACT_ADD, 0, 0, 0, 0);
        send_item(ACT_ADD, -Q1 + 100, Q1 - 100, -Q1 + 500000, Q1 - 500000);
        send_item(ACT_ADD, 2000000, 1000, 2000000, 1000);
        run_step();
        run_step();
        set_all(0, 0, 0, 65535);
        run_step();
        set_all(32'h000fffff, 32'h00100000, 32'h0fffffff, 0);
        run_step();
        set_all(32'h00100000, 32'h000fffff, 134217728, 32'hffffffff);
        run_step();
        settle();
        cfg_write(8'd4, 32'h12345678);
        cfg_write(8'hff, 32'hffffffff);
        set_all(0, 32'h001ff259, 1, 49152);
        run_step();

        for (int ph = 0; ph < 4; ph++) begin
            set_all($urandom, $urandom, $urandom_range(1000000, 12000000), $urandom);
            if (ph == 2) hold_req = 1'b1;
            for (int n = 0; n < 20; n++) begin
                if ($urandom_range(0, 3) == 0) run_step();
                else rand_add();
            end
            run_step();
        end

        settle();
        idle_en = 1'b0;
        set_all(0, 32'h001ff259, RADIUS_RST, DAMPING_RST);
        while (sb.count < MAX_PARTICLES) rand_add();
        repeat (3) rand_add();
        run_step();
        run_step();
        settle();

        if (sb.errors == 0 && sb.pos_q.size() == 0) begin
            $display("verlet_circle_collision_step regression: pass");
        end else begin
            $display("verlet_circle_collision_step regression: fail");
        end
        $finish;
    end
endmodule
